>>> sv/unique_value_list_table_defines.svh
// Assertion macros shared by the list table RTL.
`ifndef UNIQUE_VALUE_LIST_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define UVLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define UVLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/uvlt_pkg.sv
// Types and constants of the unique value list table.
`default_nettype none

package uvlt_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned POS_W          = 4;
  localparam int unsigned ECNT_W         = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic                       ins;
    logic                       del;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/uvlt_cell.sv
// One list cell: holds one entry, shifts with its neighbors, compares locally.
`default_nettype none

module uvlt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                                  clk_i,
  input  wire uvlt_pkg::cell_ctl_t                   ctl_i,
  input  wire logic signed [uvlt_pkg::VALUE_W-1:0]   prev_i,
  input  wire logic signed [uvlt_pkg::VALUE_W-1:0]   next_i,
  input  wire logic [uvlt_pkg::POS_W-1:0]            pos_i,
  input  wire logic [CNT_W-1:0]                      count_i,
  output logic signed [uvlt_pkg::VALUE_W-1:0]        entry_o,
  output logic                                       match_o
);

  logic signed [uvlt_pkg::VALUE_W-1:0] entry_q, entry_d;
  logic                                match_q, match_d;
  logic                                held, at_or_after_pos;

  // Only cells below the count hold live entries
  assign held            = (int'(count_i) > int'(IDX));
  assign at_or_after_pos = (int'(pos_i) <= int'(IDX));

  // Insert pulls from the front neighbor, delete from the back neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      entry_d = prev_i;
    end else if (ctl_i.del && at_or_after_pos) begin
      entry_d = next_i;
    end
  end

  assign match_d = held && (entry_q == ctl_i.value);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> sv/unique_value_list_table.sv
// Unique value list table: bounded ordered list of distinct values, top level.
//
// Usage: a request word (req_type_i, value_i, position_i) is taken when
// in_valid_i is high and in_stall_o is low. Each request yields exactly one
// result word (status_o, found_o, entry_count_o), offered on out_valid_o and
// taken when out_stall_i is low.
// Steps: a request passes S_CMP, where every cell compares its entry with the
// request value in parallel and registers a match flag, then S_EXEC, which ORs
// the flags, decides the status, shifts the cell row for insert or delete and
// registers the result word.
// A new request is taken in S_IDLE or in the cycle the current one completes,
// so a request is not taken while another is in S_CMP or stalled in S_EXEC.
// A waiting result does not block a new request; a request only holds in
// S_EXEC while the previous result is still stalled at the output.
// Reset: the list is emptied (count zero), no result is pending. The cell
// contents are not cleared; entries at or beyond the count are never read.
`default_nettype none

module unique_value_list_table #(
  parameter int unsigned LIST_DEPTH = uvlt_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            req_type_i,
  input  wire logic signed [uvlt_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [uvlt_pkg::POS_W-1:0]            position_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [1:0]                                 status_o,
  output logic                                       found_o,
  output logic [uvlt_pkg::ECNT_W-1:0]                entry_count_o
);

`include "unique_value_list_table_defines.svh"

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > uvlt_pkg::POS_W) ? CNT_W : uvlt_pkg::POS_W;
  localparam int unsigned EXT_W = CNT_W + uvlt_pkg::ECNT_W;

  uvlt_pkg::state_e                      state_q, state_d;
  logic [CNT_W-1:0]                      count_q, count_d;
  uvlt_pkg::req_e                        req_q;
  logic signed [uvlt_pkg::VALUE_W-1:0]   value_q;
  logic [uvlt_pkg::POS_W-1:0]            pos_q;

  logic                                  out_valid_q, out_valid_d;
  uvlt_pkg::status_e                     status_q, status_d;
  logic                                  found_q, found_d;
  logic [uvlt_pkg::ECNT_W-1:0]           ecnt_q;
  logic [EXT_W-1:0]                      count_ext;

  logic                                  in_acc, fin, hit, bad_pos;
  uvlt_pkg::cell_ctl_t                   ctl;
  logic signed [uvlt_pkg::VALUE_W-1:0]   ent [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]                 match;

  // Handshake: finish when the output register is free or being emptied
  assign fin        = (state_q == uvlt_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == uvlt_pkg::S_IDLE) || fin);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign hit     = |match;
  assign bad_pos = (CMP_W'(pos_q) >= CMP_W'(count_q));

  // Decision and cell commands for the request in S_EXEC
  always_comb begin
    count_d   = count_q;
    status_d  = uvlt_pkg::ST_DONE;
    found_d   = 1'b0;
    ctl.ins   = 1'b0;
    ctl.del   = 1'b0;
    ctl.value = value_q;
    case (req_q)
      uvlt_pkg::REQ_INSERT: begin
        if (hit) begin
          status_d = uvlt_pkg::ST_DUP;
        end else if (count_q == CNT_W'(LIST_DEPTH)) begin
          status_d = uvlt_pkg::ST_FULL;
        end else begin
          ctl.ins = fin;
          count_d = count_q + CNT_W'(1);
        end
      end
      uvlt_pkg::REQ_QUERY: begin
        found_d = hit;
      end
      uvlt_pkg::REQ_DELETE: begin
        if (bad_pos) begin
          status_d = uvlt_pkg::ST_BADPOS;
        end else begin
          ctl.del = fin;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      uvlt_pkg::S_IDLE: if (in_acc) state_d = uvlt_pkg::S_CMP;
      uvlt_pkg::S_CMP:  state_d = uvlt_pkg::S_EXEC;
      uvlt_pkg::S_EXEC: begin
        if (fin) begin
          state_d = in_acc ? uvlt_pkg::S_CMP : uvlt_pkg::S_IDLE;
        end
      end
      default: state_d = uvlt_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = fin ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uvlt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fin) begin
        count_q <= count_d;
      end
    end
  end

  // Request and result words
  assign count_ext = EXT_W'(count_d);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= uvlt_pkg::req_e'(req_type_i);
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (fin) begin
      status_q <= status_d;
      found_q  <= found_d;
      ecnt_q   <= count_ext[uvlt_pkg::ECNT_W-1:0];
    end
  end

  // Row of cells
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic signed [uvlt_pkg::VALUE_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = value_q;
    end else begin : g_mid
      assign prev_w = ent[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign next_w = ent[g];
    end else begin : g_inner
      assign next_w = ent[g+1];
    end
    uvlt_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .pos_i   (pos_q),
      .count_i (count_q),
      .entry_o (ent[g]),
      .match_o (match[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = ecnt_q;

  // Checks
  `UVLT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(LIST_DEPTH), "count beyond depth")
  `UVLT_ASSERT_IMPL(a_busy_stall, state_q == uvlt_pkg::S_CMP, in_stall_o, "taken while comparing")
  `UVLT_ASSERT_NEXT(a_count_quiet, !fin, $stable(count_q), "count moved outside update")
  `UVLT_ASSERT_IMPL(a_found_done, out_valid_q && found_q, status_q == uvlt_pkg::ST_DONE,
    "found with bad status")

endmodule

`default_nettype wire
